### rtl/core/ble_midi_to_midi_deframer_defines.svh
// Assertion macros used by the deframer parser RTL.
`ifndef BLE_MIDI_TO_MIDI_DEFRAMER_DEFINES_SVH
`define BLE_MIDI_TO_MIDI_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define BMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

### rtl/core/bmd_pkg.sv
// Package: parser phase codes, MIDI byte codes and the result bundle type.
package bmd_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_TIME   = 3'd0;
   localparam logic [2:0] PH_WAIT   = 3'd1;
   localparam logic [2:0] PH_TWO2   = 3'd2;
   localparam logic [2:0] PH_THREE2 = 3'd3;
   localparam logic [2:0] PH_THREE3 = 3'd4;
   localparam logic [2:0] PH_SYSEX  = 3'd5;

   // MIDI byte codes
   localparam logic [7:0] SYSEX_START  = 8'hf0;
   localparam logic [7:0] MTC_QUARTER  = 8'hf1;
   localparam logic [7:0] SONG_POS     = 8'hf2;
   localparam logic [7:0] SONG_SELECT  = 8'hf3;
   localparam logic [7:0] TUNE_REQUEST = 8'hf6;
   localparam logic [7:0] SYSEX_END    = 8'hf7;
   localparam logic [7:0] RT_CLOCK     = 8'hf8;
   localparam logic [7:0] RT_START     = 8'hfa;
   localparam logic [7:0] RT_CONTINUE  = 8'hfb;
   localparam logic [7:0] RT_STOP      = 8'hfc;
   localparam logic [7:0] RT_SENSING   = 8'hfe;
   localparam logic [7:0] RT_RESET     = 8'hff;
   localparam logic [3:0] HI_SYSTEM    = 4'hf;
   localparam logic [3:0] HI_PROGRAM   = 4'hc;
   localparam logic [3:0] HI_PRESSURE  = 4'hd;

   localparam int unsigned MAX_OUT = 3;
   localparam int unsigned TIME_W  = 13;

   // Up to three output words produced by one input word
   typedef struct packed {
      logic [1:0]               count;
      logic [MAX_OUT-1:0][7:0]  data;
      logic [MAX_OUT-1:0]       last;
      logic [MAX_OUT-1:0]       sysex;
      logic [TIME_W-1:0]        msg_time;
   } bmd_bundle_type;

endpackage

### rtl/core/bmd_ifs.sv
// Valid/ready stream interfaces for the request and response channels.
interface bmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_header;
   logic [7:0] in_byte;

   modport source (output valid, output packet_header, output in_byte, input ready);
   modport sink (input valid, input packet_header, input in_byte, output ready);
endinterface

interface bmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_of_message;
   logic        is_sysex;
   logic [12:0] msg_time;

   modport source (output valid, output out_byte, output last_of_message,
                   output is_sysex, output msg_time, input ready);
   modport sink (input valid, input out_byte, input last_of_message,
                 input is_sysex, input msg_time, output ready);
endinterface

### rtl/core/ble_midi_to_midi_deframer.sv
// Top level: BLE-MIDI packet deframer producing timestamped MIDI words.
//
//   channel   direction  payload
//   req_bus   in         packet_header[7:0], in_byte[7:0]
//   rsp_bus   out        out_byte[7:0], last_of_message, is_sysex, msg_time[12:0]
//
// Each request word is registered, decoded combinationally and its 0..3 result words
// are loaded into the result register, which delivers one word per cycle while
// rsp_bus.ready is high. A new bundle loads only when the register is empty or its
// last word is being taken, so the single output port limits throughput.
// Synchronous active-high reset returns to the timestamp phase with no words pending.
// A stalled response holds the result register; the input register then fills and
// req_bus.ready drops until the bundle drains.
module ble_midi_to_midi_deframer
   import bmd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bmd_req_if.sink   req_bus,
   bmd_rsp_if.source rsp_bus
);

   logic           in_valid_ff;
   logic [7:0]     hdr_ff;
   logic [7:0]     byte_ff;
   logic           can_load;
   logic           step;
   bmd_bundle_type bundle;

   // Process the registered word when the result register can take its bundle
   assign step          = in_valid_ff && can_load;
   assign req_bus.ready = !in_valid_ff || step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         hdr_ff  <= req_bus.packet_header;
         byte_ff <= req_bus.in_byte;
      end
   end

   bmd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .hdr    (hdr_ff),
      .din    (byte_ff),
      .bundle (bundle)
   );

   bmd_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

### rtl/core/bmd_parser.sv
// Parser state and single-pass step logic: one input word to a bundle of output words.
`include "ble_midi_to_midi_deframer_defines.svh"

module bmd_parser
   import bmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     hdr,
   input  logic [7:0]     din,
   output bmd_bundle_type bundle
);

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        kind_ff, kind_in;
   logic [7:0]        first_ff, first_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [7:0]        held_ff, held_in;
   logic              held_v_ff, held_v_in;

   logic [2:0] eff_phase;
   logic       go;
   logic [3:0] din_hi;
   logic [3:0] kind_hi;

   assign din_hi  = din[7:4];
   assign kind_hi = kind_ff[7:4];

   // Decode one word against the current phase
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      first_in  = first_ff;
      time_in   = time_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      bundle    = '0;
      bundle.msg_time = time_ff;
      eff_phase = phase_ff;
      go        = 1'b1;

      // Timestamp slot: drop a stray SysEx end byte, take the time, or fall into running status
      if (phase_ff == PH_TIME) begin
         if (din == SYSEX_END) begin
            go = 1'b0;
         end else if (din[7]) begin
            time_in  = {hdr[5:0], din[6:0]};
            phase_in = PH_WAIT;
            go       = 1'b0;
         end else begin
            eff_phase = PH_WAIT;
            phase_in  = PH_WAIT;
         end
      end

      if (go) begin
         case (eff_phase)
            PH_WAIT: begin
               if (din_hi == HI_SYSTEM) begin
                  case (din)
                     SYSEX_START: begin
                        kind_in   = din;
                        held_in   = din;
                        held_v_in = 1'b1;
                        phase_in  = PH_SYSEX;
                     end
                     MTC_QUARTER, SONG_SELECT: begin
                        kind_in  = din;
                        phase_in = PH_TWO2;
                     end
                     SONG_POS: begin
                        kind_in  = din;
                        phase_in = PH_THREE2;
                     end
                     TUNE_REQUEST: begin
                        kind_in        = din;
                        bundle.count   = 2'd1;
                        bundle.data[0] = din;
                        bundle.last[0] = 1'b1;
                        phase_in       = PH_TIME;
                     end
                     RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP, RT_SENSING, RT_RESET: begin
                        bundle.count   = 2'd1;
                        bundle.data[0] = din;
                        bundle.last[0] = 1'b1;
                        phase_in       = PH_TIME;
                     end
                     default: begin
                        // undefined system codes: drop
                     end
                  endcase
               end else if (din_hi == HI_PROGRAM || din_hi == HI_PRESSURE) begin
                  kind_in  = din;
                  phase_in = PH_TWO2;
               end else if (din[7]) begin
                  kind_in  = din;
                  phase_in = PH_THREE2;
               end else if (kind_ff[7] && kind_hi != HI_SYSTEM) begin
                  // Running status on a channel message
                  if (kind_hi == HI_PROGRAM || kind_hi == HI_PRESSURE) begin
                     bundle.count   = 2'd2;
                     bundle.data[0] = kind_ff;
                     bundle.data[1] = din;
                     bundle.last[1] = 1'b1;
                     phase_in       = PH_TIME;
                  end else begin
                     first_in = din;
                     phase_in = PH_THREE3;
                  end
               end
            end
            PH_TWO2: begin
               bundle.count   = 2'd2;
               bundle.data[0] = kind_ff;
               bundle.data[1] = din;
               bundle.last[1] = 1'b1;
               phase_in       = PH_TIME;
            end
            PH_THREE2: begin
               first_in = din;
               phase_in = PH_THREE3;
            end
            PH_THREE3: begin
               bundle.count   = 2'd3;
               bundle.data[0] = kind_ff;
               bundle.data[1] = first_ff;
               bundle.data[2] = din;
               bundle.last[2] = 1'b1;
               phase_in       = PH_TIME;
            end
            PH_SYSEX: begin
               // Hold one byte back so the end marker replaces the stamp before it
               if (din == SYSEX_END) begin
                  bundle.count    = 2'd1;
                  bundle.data[0]  = din;
                  bundle.last[0]  = 1'b1;
                  bundle.sysex[0] = 1'b1;
                  held_v_in       = 1'b0;
                  held_in         = '0;
                  phase_in        = PH_TIME;
               end else begin
                  if (held_v_ff) begin
                     bundle.count    = 2'd1;
                     bundle.data[0]  = held_ff;
                     bundle.sysex[0] = 1'b1;
                  end
                  held_in   = din;
                  held_v_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_TIME;
            end
         endcase
      end
   end

   // Advance state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TIME;
         kind_ff   <= '0;
         first_ff  <= '0;
         time_ff   <= '0;
         held_ff   <= '0;
         held_v_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         time_ff   <= time_in;
         held_ff   <= held_in;
         held_v_ff <= held_v_in;
      end
   end

   // A held SysEx byte exists only inside SysEx
   `BMD_ASSERT_NOW(a_held_in_sysex, clock, reset, held_v_ff, phase_ff == PH_SYSEX)
   // Three-word bursts come only from the third-byte phase
   `BMD_ASSERT_NOW(a_three_from_phase, clock, reset, step && bundle.count == 2'd3,
                   phase_ff == PH_THREE3)
   // A timestamp byte loads the 13-bit time
   `BMD_ASSERT_NEXT(a_time_load, clock, reset,
                    step && phase_ff == PH_TIME && din[7] && din != SYSEX_END,
                    time_ff == $past({hdr[5:0], din[6:0]}))

endmodule

### rtl/core/bmd_outbuf.sv
// Result register: holds one bundle and hands its words out one per cycle while ready is high.
module bmd_outbuf
   import bmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bmd_bundle_type   bundle,
   output logic             can_load,
   bmd_rsp_if.source        rsp_bus
);

   bmd_bundle_type bundle_ff;
   logic [1:0]     rem_ff, rem_in;
   logic [1:0]     pos_ff, pos_in;
   logic           take;

   assign take     = rsp_bus.valid && rsp_bus.ready;
   assign can_load = (rem_ff == 2'd0) || (rem_ff == 2'd1 && take);

   // Drive the current word
   assign rsp_bus.valid           = (rem_ff != 2'd0);
   assign rsp_bus.out_byte        = bundle_ff.data[pos_ff];
   assign rsp_bus.last_of_message = bundle_ff.last[pos_ff];
   assign rsp_bus.is_sysex        = bundle_ff.sysex[pos_ff];
   assign rsp_bus.msg_time        = bundle_ff.msg_time;

   // Load a new bundle or advance through the held one
   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (load) begin
         rem_in = bundle.count;
         pos_in = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 2'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule
